// ===== sv/ccfb_pkg.sv =====
package ccfb_pkg;

    // Frame store size limits
    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 64;

    // Field widths of the streams and the configuration port
    localparam int CMD_W      = 2;
    localparam int POS_W      = 16;
    localparam int GLYPH_W    = 8;
    localparam int ATTR_W     = 16;
    localparam int CELL_W     = GLYPH_W + ATTR_W;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Screen coordinates: width fits 8 bits, height 7 bits, clip bounds signed 10 bits
    localparam int COL_W = 8;
    localparam int ROW_W = 7;
    localparam int GEO_W = 10;
    localparam int LIN_W = 16;

    // Power of two so the pointers wrap on their own
    localparam int QUEUE_DEPTH = 2;

    localparam logic [GLYPH_W-1:0] BLANK_GLYPH     = 8'h20;
    localparam logic [ATTR_W-1:0]  CHECK_ATTR_ODD  = 16'h00C0;
    localparam logic [ATTR_W-1:0]  CHECK_ATTR_EVEN = 16'h00A0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VIEW_WIDTH  = 4'd0,
        REG_VIEW_HEIGHT = 4'd1,
        REG_CAMERA_X    = 4'd2,
        REG_CAMERA_Y    = 4'd3,
        REG_CLIP_LEFT   = 4'd4,
        REG_CLIP_TOP    = 4'd5,
        REG_CLIP_RIGHT  = 4'd6,
        REG_CLIP_BOTTOM = 4'd7
    } cfg_reg_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_DRAW  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_CLEAR,
        OP_REJECT
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_CLEAR
    } back_state_t;

    // Window geometry derived from the configuration registers
    typedef struct packed {
        logic [COL_W-1:0]        width;
        logic [ROW_W-1:0]        height;
        logic signed [GEO_W-1:0] left;
        logic signed [GEO_W-1:0] right;
        logic signed [GEO_W-1:0] top;
        logic signed [GEO_W-1:0] bottom;
        logic signed [POS_W-1:0] cam_x;
        logic signed [POS_W-1:0] cam_y;
        logic                    parity;
        logic                    empty;
    } geom_t;

    // Classified work item handed from front to back
    typedef struct packed {
        op_t                op;
        logic [LIN_W-1:0]   lin;
        logic [GLYPH_W-1:0] glyph;
        logic [ATTR_W-1:0]  attr;
    } work_t;

endpackage

// ===== sv/ccfb_front.sv =====
module ccfb_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pos_x[15:0], pos_y[31:16], glyph[39:32], attribute[55:40]
    input  logic [ccfb_pkg::IN_DATA_W-1:0]     s_tdata,
    // cmd[1:0]
    input  logic [ccfb_pkg::CMD_W-1:0]         s_tuser,
    input  ccfb_pkg::geom_t                    geom,
    input  logic                               q_full,
    output logic                               q_push,
    output ccfb_pkg::work_t                    q_item
);
    import ccfb_pkg::*;

    typedef struct packed {
        op_t                op;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [GLYPH_W-1:0] glyph;
        logic [ATTR_W-1:0]  attr;
    } stage_t;

    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    stage_t                  s1_reg;
    stage_t                  s1_next;
    logic                    accept;
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic signed [POS_W:0]   scr_x;
    logic signed [POS_W:0]   scr_y;
    logic signed [POS_W:0]   lo_x;
    logic signed [POS_W:0]   hi_x;
    logic signed [POS_W:0]   lo_y;
    logic signed [POS_W:0]   hi_y;
    logic                    draw_hit;
    logic                    read_hit;
    logic [LIN_W-1:0]        row_base;

    assign pos_x = s_tdata[15:0];
    assign pos_y = s_tdata[31:16];

    // World to screen
    assign scr_x = {pos_x[POS_W-1], pos_x} - {geom.cam_x[POS_W-1], geom.cam_x};
    assign scr_y = {pos_y[POS_W-1], pos_y} - {geom.cam_y[POS_W-1], geom.cam_y};
    assign lo_x  = {{(POS_W+1-GEO_W){geom.left[GEO_W-1]}}, geom.left};
    assign hi_x  = {{(POS_W+1-GEO_W){geom.right[GEO_W-1]}}, geom.right};
    assign lo_y  = {{(POS_W+1-GEO_W){geom.top[GEO_W-1]}}, geom.top};
    assign hi_y  = {{(POS_W+1-GEO_W){geom.bottom[GEO_W-1]}}, geom.bottom};

    assign draw_hit = (scr_x >= lo_x) && (scr_x <= hi_x) && (scr_y >= lo_y) && (scr_y <= hi_y);
    assign read_hit = !pos_x[POS_W-1] && (pos_x[POS_W-2:0] < {7'd0, geom.width})
                   && !pos_y[POS_W-1] && (pos_y[POS_W-2:0] < {8'd0, geom.height});

    assign q_push   = s1_valid_reg && !q_full;
    assign s_tready = !s1_valid_reg || q_push;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        s1_next.col   = pos_x[COL_W-1:0];
        s1_next.row   = pos_y[ROW_W-1:0];
        s1_next.glyph = s_tdata[39:32];
        s1_next.attr  = s_tdata[55:40];
        case (s_tuser)
            CMD_DRAW: begin
                s1_next.op  = draw_hit ? OP_WRITE : OP_REJECT;
                s1_next.col = scr_x[COL_W-1:0];
                s1_next.row = scr_y[ROW_W-1:0];
            end
            CMD_CLEAR: s1_next.op = OP_CLEAR;
            CMD_READ:  s1_next.op = read_hit ? OP_READ : OP_REJECT;
            default:   s1_next.op = OP_REJECT;
        endcase
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (q_push) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= s1_next;
        end
    end

    // Linear cell index y*width + x
    assign row_base     = {{(LIN_W-ROW_W){1'b0}}, s1_reg.row}
                        * {{(LIN_W-COL_W){1'b0}}, geom.width};
    assign q_item.op    = s1_reg.op;
    assign q_item.lin   = row_base + {8'd0, s1_reg.col};
    assign q_item.glyph = s1_reg.glyph;
    assign q_item.attr  = s1_reg.attr;

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !q_push |=> s1_valid_reg && $stable(s1_reg))
        else $error("front stage lost a stalled item");

endmodule

// ===== sv/ccfb_queue.sv =====
module ccfb_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ccfb_pkg::work_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            avail,
    output ccfb_pkg::work_t head
);
    import ccfb_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    work_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             do_pop;

    assign full   = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign avail  = (count_reg != '0);
    assign head   = slot_reg[rd_ptr_reg];
    assign do_pop = pop && avail;

    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into a full queue");

endmodule

// ===== sv/ccfb_back.sv =====
module ccfb_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ccfb_pkg::geom_t                    geom,
    input  logic                               q_avail,
    input  ccfb_pkg::work_t                    q_head,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // cell_glyph[7:0], cell_attribute[23:8]
    output logic [ccfb_pkg::OUT_DATA_W-1:0]    m_tdata,
    // accepted[0]
    output logic [0:0]                         m_tuser
);
    import ccfb_pkg::*;

    localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [CELL_W-1:0]  mem [DEPTH];
    logic [CELL_W-1:0]  rdata_reg;

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic [LIN_W-1:0]   base_reg;
    logic [LIN_W-1:0]   base_next;
    logic [LIN_W-1:0]   first_base;
    logic [LIN_W-1:0]   clear_lin;
    logic               last_col;
    logic               last_row;
    logic               check_odd;

    logic               m_valid_reg;
    logic               m_valid_next;
    logic               m_acc_reg;
    logic [CELL_W-1:0]  m_cell_reg;

    logic               out_free;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic               mem_re;
    logic               load_out;
    logic               out_acc;
    logic [CELL_W-1:0]  out_cell;
    logic               start_clear;

    assign out_free = !m_valid_reg || m_tready;
    assign q_pop    = (state_reg == BK_IDLE) && q_avail && out_free;

    assign first_base = {{(LIN_W-ROW_W){1'b0}}, geom.top[ROW_W-1:0]}
                      * {{(LIN_W-COL_W){1'b0}}, geom.width};
    assign clear_lin  = base_reg + {8'd0, col_reg};
    assign last_col   = (col_reg == geom.right[COL_W-1:0]);
    assign last_row   = (row_reg == geom.bottom[ROW_W-1:0]);
    assign check_odd  = geom.parity ^ geom.right[0] ^ geom.bottom[0] ^ 1'b1
                      ^ col_reg[0] ^ row_reg[0];
    assign start_clear = q_pop && (q_head.op == OP_CLEAR) && !geom.empty;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (q_pop && q_head.op == OP_READ) begin
                    state_next = BK_READ;
                end else if (start_clear) begin
                    state_next = BK_CLEAR;
                end
            end
            BK_READ:  state_next = BK_IDLE;
            BK_CLEAR: begin
                if (last_col && last_row) begin
                    state_next = BK_IDLE;
                end
            end
            default:  state_next = BK_IDLE;
        endcase
    end

    // Memory and result controls
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = q_head.lin[ADDR_W-1:0];
        mem_wdata = {q_head.glyph, q_head.attr};
        mem_re    = 1'b0;
        load_out  = 1'b0;
        out_acc   = 1'b0;
        out_cell  = '0;
        case (state_reg)
            BK_IDLE: begin
                if (q_pop) begin
                    case (q_head.op)
                        OP_WRITE: begin
                            mem_we   = 1'b1;
                            load_out = 1'b1;
                            out_acc  = 1'b1;
                        end
                        OP_READ:  mem_re = 1'b1;
                        OP_CLEAR: begin
                            load_out = geom.empty;
                            out_acc  = 1'b1;
                        end
                        default:  load_out = 1'b1;
                    endcase
                end
            end
            BK_READ: begin
                load_out = 1'b1;
                out_acc  = 1'b1;
                out_cell = rdata_reg;
            end
            BK_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clear_lin[ADDR_W-1:0];
                mem_wdata = {BLANK_GLYPH, check_odd ? CHECK_ATTR_ODD : CHECK_ATTR_EVEN};
                load_out  = last_col && last_row;
                out_acc   = 1'b1;
            end
            default: ;
        endcase
    end

    // Clear walk: column fastest, row base advances by one frame width
    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        base_next = base_reg;
        if (start_clear) begin
            col_next  = geom.left[COL_W-1:0];
            row_next  = geom.top[ROW_W-1:0];
            base_next = first_base;
        end else if (state_reg == BK_CLEAR) begin
            if (last_col && last_row) begin
                col_next  = '0;
                row_next  = '0;
                base_next = '0;
            end else if (last_col) begin
                col_next  = geom.left[COL_W-1:0];
                row_next  = row_reg + 1'b1;
                base_next = base_reg + {8'd0, geom.width};
            end else begin
                col_next  = col_reg + 1'b1;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            base_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            base_reg    <= base_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_acc_reg  <= out_acc;
            m_cell_reg <= out_cell;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[q_head.lin[ADDR_W-1:0]];
        end
    end

    // Glyph goes in the low byte of the stream, attribute above it
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {m_cell_reg[ATTR_W-1:0], m_cell_reg[CELL_W-1:ATTR_W]};
    assign m_tuser[0] = m_acc_reg;

    a_read_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_READ |-> !m_valid_reg)
        else $error("read data arrives with the result register occupied");

    a_walk_parked: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_IDLE |-> col_reg == '0 && row_reg == '0)
        else $error("clear counters not parked while idle");

    a_clear_ends_in_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_CLEAR && state_next == BK_IDLE |=> m_valid_reg && m_acc_reg)
        else $error("finished clear gave no result");

endmodule

// ===== sv/clipped_char_cell_framebuffer.sv =====
// Path: draw, clear with an empty window and rejected items pass the front stage
// register, queue and result register; a read also passes the read register.
// Throughput: one draw or reject per cycle while m_tready is high; a read or
// a clear takes no new item until done; clears use the single cell store port.
// Reset (aresetn low, synchronous) empties the queue and the result register and
// restores the registers to 80x25, camera 0,0, no clipping; cells are not cleared.
module clipped_char_cell_framebuffer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pos_x[15:0], pos_y[31:16], glyph[39:32], attribute[55:40]
    input  logic [ccfb_pkg::IN_DATA_W-1:0]     s_tdata,
    // cmd[1:0]
    input  logic [ccfb_pkg::CMD_W-1:0]         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // cell_glyph[7:0], cell_attribute[23:8]
    output logic [ccfb_pkg::OUT_DATA_W-1:0]    m_tdata,
    // accepted[0]
    output logic [0:0]                         m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ccfb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ccfb_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ccfb_pkg::*;

    logic [7:0]              view_width_reg;
    logic [6:0]              view_height_reg;
    logic [15:0]             camera_x_reg;
    logic [15:0]             camera_y_reg;
    logic [6:0]              clip_left_reg;
    logic [5:0]              clip_top_reg;
    logic [6:0]              clip_right_reg;
    logic [5:0]              clip_bottom_reg;

    logic [COL_W-1:0]        eff_width;
    logic [ROW_W-1:0]        eff_height;
    logic signed [GEO_W-1:0] win_right;
    logic signed [GEO_W-1:0] win_bottom;
    logic signed [GEO_W-1:0] win_left;
    logic signed [GEO_W-1:0] win_top;
    geom_t                   geom;

    logic                    q_full;
    logic                    q_push;
    work_t                   q_item;
    logic                    q_pop;
    logic                    q_avail;
    work_t                   q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            view_width_reg  <= 8'd80;
            view_height_reg <= 7'd25;
            camera_x_reg    <= '0;
            camera_y_reg    <= '0;
            clip_left_reg   <= '0;
            clip_top_reg    <= '0;
            clip_right_reg  <= '0;
            clip_bottom_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_VIEW_WIDTH:  view_width_reg  <= cfg_data[7:0];
                REG_VIEW_HEIGHT: view_height_reg <= cfg_data[6:0];
                REG_CAMERA_X:    camera_x_reg    <= cfg_data;
                REG_CAMERA_Y:    camera_y_reg    <= cfg_data;
                REG_CLIP_LEFT:   clip_left_reg   <= cfg_data[6:0];
                REG_CLIP_TOP:    clip_top_reg    <= cfg_data[5:0];
                REG_CLIP_RIGHT:  clip_right_reg  <= cfg_data[6:0];
                REG_CLIP_BOTTOM: clip_bottom_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Saturate the frame size to 1..MAX
    always_comb begin
        if (view_width_reg == '0) begin
            eff_width = COL_W'(1);
        end else if ({1'b0, view_width_reg} > 9'(MAX_COLUMNS)) begin
            eff_width = COL_W'(MAX_COLUMNS);
        end else begin
            eff_width = view_width_reg;
        end
        if (view_height_reg == '0) begin
            eff_height = ROW_W'(1);
        end else if ({2'b00, view_height_reg} > 9'(MAX_ROWS)) begin
            eff_height = ROW_W'(MAX_ROWS);
        end else begin
            eff_height = view_height_reg;
        end
    end

    assign win_left   = {3'b000, clip_left_reg};
    assign win_top    = {4'b0000, clip_top_reg};
    assign win_right  = {2'b00, eff_width} - {3'b000, clip_right_reg} - 10'd1;
    assign win_bottom = {3'b000, eff_height} - {4'b0000, clip_bottom_reg} - 10'd1;

    assign geom.width  = eff_width;
    assign geom.height = eff_height;
    assign geom.left   = win_left;
    assign geom.right  = win_right;
    assign geom.top    = win_top;
    assign geom.bottom = win_bottom;
    assign geom.cam_x  = camera_x_reg;
    assign geom.cam_y  = camera_y_reg;
    assign geom.parity = camera_x_reg[0] ^ camera_y_reg[0];
    assign geom.empty  = (win_left > win_right) || (win_top > win_bottom);

    ccfb_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .geom     (geom),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_item)
    );

    ccfb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .avail     (q_avail),
        .head      (q_head)
    );

    ccfb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .geom     (geom),
        .q_avail  (q_avail),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
